@@ design/assert_macros.svh @@
// Assertion macros used by the walker top RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent check, held off while reset is asserted (active-low reset).
`define SCW_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Concurrent check that also applies during reset.
`define SCW_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCW_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define SCW_ASSERT_ALL(lbl, clk, prop, msg)
`endif

`endif

@@ design/scw_pkg.sv @@
// Shared types and constants of the sector chain walker.
`default_nettype none

package scw_pkg;

    localparam int unsigned SECT_W    = 16;
    localparam int unsigned POS_W     = 24;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned STAT_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned EPOCH_W   = 8;

    localparam int unsigned SECTOR_SPACE_DEF = 65536;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

    localparam logic [POS_W-1:0]  POS_MAX   = {POS_W{1'b1}};
    localparam logic [SECT_W-1:0] LINK_MASK_SHORT = SECT_W'(16'h03FF);
    localparam logic [SECT_W-1:0] FIRST_DATA_SECT = SECT_W'(2);
    localparam logic [BYTE_W-1:0] LEN_MASK_LAST   = BYTE_W'(8'h7F);

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_CONTINUE = 2'd0;
    localparam logic [STAT_W-1:0] ST_END      = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd2;
    localparam logic [STAT_W-1:0] ST_LOOP     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_PAYLOAD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_DISK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT   = 3'd4;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0] FULL_PAYLOAD_RST = 8'd125;
    localparam logic              COUNTED_RST      = 1'b1;
    localparam logic              EXTENDED_RST     = 1'b0;
    localparam logic              LARGE_DISK_RST   = 1'b0;
    localparam logic [POS_W-1:0]  BYTE_LIMIT_RST   = '0;

    // Decoded sector trailer.
    typedef struct packed {
        logic [BYTE_W-1:0] len;
        logic [SECT_W-1:0] link;
    } t_trailer;

endpackage

`default_nettype wire

@@ design/scw_ifs.sv @@
// Channel interfaces: input items, results and configuration writes.
`default_nettype none

interface scw_in_if;
    logic                        valid;
    logic                        ready;
    logic                        start_chain;
    logic [scw_pkg::SECT_W-1:0]  sector_number;
    logic                        sector_present;
    logic [scw_pkg::BYTE_W-1:0]  link_high;
    logic [scw_pkg::BYTE_W-1:0]  link_low;
    logic [scw_pkg::BYTE_W-1:0]  count_byte;

    modport source (
        output valid, start_chain, sector_number, sector_present,
               link_high, link_low, count_byte,
        input  ready
    );
    modport sink (
        input  valid, start_chain, sector_number, sector_present,
               link_high, link_low, count_byte,
        output ready
    );
endinterface

interface scw_out_if;
    logic                        valid;
    logic                        ready;
    logic [scw_pkg::POS_W-1:0]   copy_offset;
    logic [scw_pkg::BYTE_W-1:0]  copy_length;
    logic [scw_pkg::SECT_W-1:0]  next_sector;
    logic [scw_pkg::POS_W-1:0]   total_bytes;
    logic [scw_pkg::STAT_W-1:0]  chain_status;
    logic                        over_limit;

    modport source (
        output valid, copy_offset, copy_length, next_sector, total_bytes,
               chain_status, over_limit,
        input  ready
    );
    modport sink (
        input  valid, copy_offset, copy_length, next_sector, total_bytes,
               chain_status, over_limit,
        output ready
    );
endinterface

interface scw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [scw_pkg::CFG_IDX_W-1:0] reg_index;
    logic [scw_pkg::POS_W-1:0]     wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

@@ design/sector_chain_walker_top.sv @@
// Sector chain walker: follows a linked sector chain, tracks visited sectors and buffer offsets.
//
//  channel  dir  transfer when        carries
//  i_in     in   valid && ready       start flag, sector number, presence, trailer bytes
//  o_out    out  valid && ready       offset, copy length, next sector, total, status, flag
//  i_cfg    in   valid && ready       register index, write data (ready always high)
//
//  One item per cycle unless the output stalls or a clear runs; stage 1 feeds the output stage.
//  The visited map is a one-port-read, one-port-write memory of epoch marks, read for each item,
//  written for each new one; a write to the sector being read is forwarded except on a start.
//  After reset a clearing pass over all SECTOR_SPACE marks runs before the first item is taken,
//  and the same pass runs once the epoch count is used up (a start after 255 chains).
//  A stalled result holds stage 2; with stage 1 full, input ready drops in the same cycle.
`default_nettype none
`include "assert_macros.svh"

module sector_chain_walker_top #(
    parameter int unsigned SECTOR_SPACE = scw_pkg::SECTOR_SPACE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scw_in_if.sink    i_in,
    scw_out_if.source o_out,
    scw_cfg_if.sink   i_cfg
);

    localparam int unsigned AW = $clog2(SECTOR_SPACE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SECTOR_SPACE - 1);
    localparam logic [scw_pkg::SECT_W:0] SPACE_LIM = (scw_pkg::SECT_W+1)'(SECTOR_SPACE);

    // Configuration registers.
    logic [scw_pkg::BYTE_W-1:0] r_full_payload;
    logic                       r_counted;
    logic                       r_extended;
    logic                       r_large_disk;
    logic [scw_pkg::POS_W-1:0]  r_byte_limit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_payload <= scw_pkg::FULL_PAYLOAD_RST;
            r_counted      <= scw_pkg::COUNTED_RST;
            r_extended     <= scw_pkg::EXTENDED_RST;
            r_large_disk   <= scw_pkg::LARGE_DISK_RST;
            r_byte_limit   <= scw_pkg::BYTE_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                scw_pkg::CFG_FULL_PAYLOAD: r_full_payload <= i_cfg.wr_data[scw_pkg::BYTE_W-1:0];
                scw_pkg::CFG_COUNTED:      r_counted      <= i_cfg.wr_data[0];
                scw_pkg::CFG_EXTENDED:     r_extended     <= i_cfg.wr_data[0];
                scw_pkg::CFG_LARGE_DISK:   r_large_disk   <= i_cfg.wr_data[0];
                scw_pkg::CFG_BYTE_LIMIT:   r_byte_limit   <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    // Control state.
    logic                        r_sweep;
    logic [AW-1:0]               r_sweep_addr;
    logic [scw_pkg::EPOCH_W-1:0] r_epoch;
    logic                        r_fresh;
    logic [scw_pkg::POS_W-1:0]   r_position;
    logic                        r1_valid;
    logic                        r_out_valid;

    // Stage 1 payload.
    logic                        r1_start;
    logic [scw_pkg::SECT_W-1:0]  r1_sect;
    logic                        r1_ok_sect;
    logic [scw_pkg::EPOCH_W-1:0] r1_epoch;
    logic                        r1_fwd_hit;
    scw_pkg::t_trailer           r1_dec;

    // Visited map: one epoch mark per sector.
    logic [scw_pkg::EPOCH_W-1:0] r_map [SECTOR_SPACE];
    logic [scw_pkg::EPOCH_W-1:0] r_map_q;

    logic                        in_acc;
    logic                        s1_adv;
    logic                        s1_wr;
    logic                        need_sweep;
    logic [scw_pkg::EPOCH_W-1:0] item_epoch;
    logic                        in_ok_sect;
    scw_pkg::t_trailer           in_dec;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [scw_pkg::EPOCH_W-1:0] mem_wdata;

    scw_trailer_dec u_dec (
        .i_counted      (r_counted),
        .i_extended     (r_extended),
        .i_large_disk   (r_large_disk),
        .i_full_payload (r_full_payload),
        .i_link_high    (i_in.link_high),
        .i_link_low     (i_in.link_low),
        .i_count_byte   (i_in.count_byte),
        .o_dec          (in_dec)
    );

    assign s1_adv     = r1_valid && (!r_out_valid || o_out.ready);
    assign need_sweep = i_in.valid && i_in.start_chain && !r_fresh
                        && (r_epoch == scw_pkg::EPOCH_LAST);
    assign i_in.ready = !r_sweep && !need_sweep && (!r1_valid || s1_adv);
    assign in_acc     = i_in.valid && i_in.ready;
    assign item_epoch = (i_in.start_chain && !r_fresh) ? r_epoch + 1'b1 : r_epoch;
    assign in_ok_sect = i_in.sector_present && (i_in.sector_number >= scw_pkg::FIRST_DATA_SECT)
                        && ({1'b0, i_in.sector_number} < SPACE_LIM);

    // Stage 1: compare mark, update position.
    logic                       visited;
    logic                       ok_item;
    logic [scw_pkg::POS_W-1:0]  pos0;
    logic [scw_pkg::POS_W-1:0]  room;
    logic [scw_pkg::POS_W:0]    sum;
    logic [scw_pkg::POS_W-1:0]  pos_new;
    logic [scw_pkg::POS_W-1:0]  n_position;
    logic [scw_pkg::BYTE_W-1:0] copy_len;
    logic [scw_pkg::STAT_W-1:0] status;

    always_comb begin
        visited  = r1_ok_sect && (r1_fwd_hit || (r_map_q == r1_epoch));
        ok_item  = r1_ok_sect && !visited;
        pos0     = r1_start ? '0 : r_position;
        room     = r_byte_limit - pos0;
        sum      = {1'b0, pos0} + {{(scw_pkg::POS_W+1-scw_pkg::BYTE_W){1'b0}}, r1_dec.len};
        pos_new  = sum[scw_pkg::POS_W] ? scw_pkg::POS_MAX : sum[scw_pkg::POS_W-1:0];
        copy_len = '0;
        if (ok_item && (r_byte_limit > pos0)) begin
            if (room > {{(scw_pkg::POS_W-scw_pkg::BYTE_W){1'b0}}, r1_dec.len}) begin
                copy_len = r1_dec.len;
            end else begin
                copy_len = room[scw_pkg::BYTE_W-1:0];
            end
        end
        n_position = ok_item ? pos_new : pos0;
        if (!r1_ok_sect) begin
            status = scw_pkg::ST_INVALID;
        end else if (visited) begin
            status = scw_pkg::ST_LOOP;
        end else if (r1_dec.link != '0) begin
            status = scw_pkg::ST_CONTINUE;
        end else begin
            status = scw_pkg::ST_END;
        end
    end

    assign s1_wr     = s1_adv && ok_item;
    assign mem_we    = r_sweep || s1_wr;
    assign mem_waddr = r_sweep ? r_sweep_addr : r1_sect[AW-1:0];
    assign mem_wdata = r_sweep ? '0 : r1_epoch;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        if (in_acc) begin
            r_map_q <= r_map[i_in.sector_number[AW-1:0]];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
            r_epoch      <= scw_pkg::EPOCH_FIRST;
            r_fresh      <= 1'b0;
            r_position   <= '0;
            r1_valid     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
                if (r_sweep_addr == LAST_ADDR) begin
                    r_sweep <= 1'b0;
                    r_epoch <= scw_pkg::EPOCH_FIRST;
                    r_fresh <= 1'b1;
                end
            end else if (need_sweep && !r1_valid) begin
                // Marks are about to wrap: wipe the map before the start goes in.
                r_sweep      <= 1'b1;
                r_sweep_addr <= '0;
            end
            if (in_acc) begin
                r_epoch <= item_epoch;
                r_fresh <= 1'b0;
            end
            if (in_acc) begin
                r1_valid <= 1'b1;
            end else if (s1_adv) begin
                r1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_position  <= n_position;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_start   <= i_in.start_chain;
            r1_sect    <= i_in.sector_number;
            r1_ok_sect <= in_ok_sect;
            r1_epoch   <= item_epoch;
            r1_dec     <= in_dec;
            // Forward the mark written at the same edge as this read.
            r1_fwd_hit <= s1_wr && (r1_sect == i_in.sector_number) && !i_in.start_chain;
        end
        if (s1_adv) begin
            o_out.copy_offset  <= pos0;
            o_out.copy_length  <= copy_len;
            o_out.next_sector  <= ok_item ? r1_dec.link : '0;
            o_out.total_bytes  <= n_position;
            o_out.chain_status <= status;
            o_out.over_limit   <= n_position > r_byte_limit;
        end
    end

    assign o_out.valid = r_out_valid;

    `SCW_ASSERT_RST(a_no_take_in_sweep, i_clk, i_rst_n, (r_sweep |-> !in_acc), "item taken during map clear")
    `SCW_ASSERT_RST(a_one_writer, i_clk, i_rst_n, (!(r_sweep && s1_wr)), "map written by clear and item together")
    `SCW_ASSERT_RST(a_epoch_nonzero, i_clk, i_rst_n, (!r_sweep |-> (r_epoch != '0)), "epoch mark zero while in use")
    `SCW_ASSERT_RST(a_pos_grows, i_clk, i_rst_n, ((s1_adv && !r1_start) |-> (n_position >= r_position)), "position went back within a chain")
    `SCW_ASSERT_RST(a_loop_empty, i_clk, i_rst_n, ((o_out.valid && (o_out.chain_status == scw_pkg::ST_LOOP)) |-> ((o_out.copy_length == '0) && (o_out.next_sector == '0))), "loop result carries data")

endmodule

`default_nettype wire

@@ design/scw_trailer_dec.sv @@
// Trailer decoder: data length and next-sector link from the three trailer bytes.
`default_nettype none

module scw_trailer_dec (
    input  logic                       i_counted,
    input  logic                       i_extended,
    input  logic                       i_large_disk,
    input  logic [scw_pkg::BYTE_W-1:0] i_full_payload,
    input  logic [scw_pkg::BYTE_W-1:0] i_link_high,
    input  logic [scw_pkg::BYTE_W-1:0] i_link_low,
    input  logic [scw_pkg::BYTE_W-1:0] i_count_byte,
    output scw_pkg::t_trailer          o_dec
);

    logic [scw_pkg::BYTE_W-1:0] len;
    logic [scw_pkg::SECT_W-1:0] link;

    always_comb begin
        len  = i_count_byte;
        link = {i_link_high, i_link_low};
        // Old format: top bit of the count flags the last sector.
        if (!i_counted && !i_extended) begin
            if (i_count_byte[scw_pkg::BYTE_W-1]) begin
                len  = i_count_byte & scw_pkg::LEN_MASK_LAST;
                link = '0;
            end else begin
                len = i_full_payload;
            end
        end
        if (!i_extended || !i_large_disk) begin
            link = link & scw_pkg::LINK_MASK_SHORT;
        end
        o_dec.len  = len;
        o_dec.link = link;
    end

endmodule

`default_nettype wire
